// ===== design/lie_pkg.sv =====
// shared types, codes and the saturating clamp for the lagrange evaluator
`default_nettype none
package lie_pkg;

    localparam int WORD_W = 32;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 66;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DUP = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP_I,
        ST_DUP_J,
        ST_DUP_C,
        ST_EV_I,
        ST_EV_IW,
        ST_EV_J,
        ST_EV_JW,
        ST_EV_MUL,
        ST_EV_DIV,
        ST_EV_Y,
        ST_EV_YW,
        ST_EV_TERM,
        ST_OUT
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_alu_rsp;

    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] value;
    } t_clamp;

    // signed result from sign and magnitude, saturated to 32 bits
    function automatic t_clamp clamp_mag(input logic neg, input logic [PROD_W-1:0] mag);
        t_clamp r;
        logic [PROD_W-1:0] negm;
        r = '0;
        negm = '0 - mag;
        if (neg) begin
            if (mag > PROD_W'(64'h8000_0000)) begin
                r.sat = 1'b1;
                r.value = 32'h8000_0000;
            end else begin
                r.value = negm[WORD_W-1:0];
            end
        end else begin
            if (mag > PROD_W'(64'h7fff_ffff)) begin
                r.sat = 1'b1;
                r.value = 32'h7fff_ffff;
            end else begin
                r.value = mag[WORD_W-1:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/lie_in_if.sv =====
// input item channel
`default_nettype none
interface lie_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [lie_pkg::IDX_W-1:0]        point_index;
    logic signed [lie_pkg::WORD_W-1:0] x_value;
    logic signed [lie_pkg::WORD_W-1:0] y_value;
    modport source(output valid, cmd, point_index, x_value, y_value, input ready);
    modport sink(input valid, cmd, point_index, x_value, y_value, output ready);
endinterface
`default_nettype wire

// ===== design/lie_out_if.sv =====
// result channel
`default_nettype none
interface lie_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [lie_pkg::WORD_W-1:0] interp_value;
    logic [1:0]                       status;
    modport source(output valid, interp_value, status, input ready);
    modport sink(input valid, interp_value, status, output ready);
endinterface
`default_nettype wire

// ===== design/lie_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface lie_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [lie_pkg::CFG_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/lie_alu.sv =====
// shared bit-serial multiply / divide unit with saturation
`default_nettype none
module lie_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lie_pkg::t_alu_req                 i_req,
    input  wire logic signed [lie_pkg::DIFF_W-1:0] i_a,
    input  wire logic signed [lie_pkg::DIFF_W-1:0] i_b,
    output lie_pkg::t_alu_rsp                      o_rsp,
    output logic [lie_pkg::WORD_W-1:0]             o_result
);
    localparam int DW        = lie_pkg::DIFF_W;
    localparam int PW        = lie_pkg::PROD_W;
    localparam int MUL_STEPS = DW;
    localparam int DIV_STEPS = DW + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    lie_pkg::t_alu_op  r_op;
    logic              r_neg;
    logic [DW-1:0]     r_ma;
    logic [DW-1:0]     r_mb;
    logic [PW-1:0]     r_acc;
    logic [DW-1:0]     r_rem;
    logic [DIV_STEPS-1:0] r_q;
    logic [DIV_STEPS-1:0] r_num;
    logic              r_done;
    logic              r_sat;
    logic [lie_pkg::WORD_W-1:0] r_res;

    logic [DW-1:0]     ma;
    logic [DW-1:0]     mb;
    logic [DW:0]       rem_sh;
    logic              ge;
    logic [DW:0]       rem_sub;
    logic [PW-1:0]     fin_mag;
    lie_pkg::t_clamp   fin;

    always_comb begin
        ma = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
        mb = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
        rem_sh = {r_rem, r_num[DIV_STEPS-1]};
        ge = rem_sh >= {1'b0, r_mb};
        rem_sub = rem_sh - {1'b0, r_mb};
        if (r_op == lie_pkg::OP_MUL) begin
            fin_mag = r_acc >> FRAC_BITS;
        end else begin
            fin_mag = PW'(r_q);
        end
        fin = lie_pkg::clamp_mag(r_neg, fin_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == lie_pkg::OP_MUL) ? CNT_W'(MUL_STEPS)
                                                        : CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_a[DW-1] ^ i_b[DW-1];
            r_ma  <= ma;
            r_mb  <= mb;
            r_acc <= '0;
            r_rem <= '0;
            r_q   <= '0;
            r_num <= {ma, FRAC_BITS'(0)};
        end else if (r_busy && r_cnt != '0) begin
            if (r_op == lie_pkg::OP_MUL) begin
                // msb-first shift and add
                r_acc <= {r_acc[PW-2:0], 1'b0} + (r_mb[DW-1] ? PW'(r_ma) : PW'(0));
                r_mb  <= {r_mb[DW-2:0], 1'b0};
            end else begin
                // restoring division, one quotient bit per cycle
                r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_q   <= {r_q[DIV_STEPS-2:0], ge};
                r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            end
        end else if (r_busy) begin
            r_res <= fin.value;
            r_sat <= fin.sat;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_result   = r_res;

endmodule
`default_nettype wire

// ===== design/lagrange_interpolation_eval_unit.sv =====
// lagrange interpolation evaluator: point store, sequencer and result register
// load beat: stores one point, no result; evaluate beat with n points: a duplicate
// check over every pair of abscissae (skipped for one point), then per point i a basis
// product and quotient for each other point and a product with y, all run on the shared
// bit-serial mul/div unit; one item at a time, ready only when idle
// reset clears control, the point count (to 1) and the result valid; stores are not cleared
`default_nettype none
module lagrange_interpolation_eval_unit #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lie_in_if.sink     i_in,
    lie_out_if.source  o_out,
    lie_cfg_if.sink    i_cfg
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WW = lie_pkg::WORD_W;
    localparam int DW = lie_pkg::DIFF_W;
    localparam int PW = lie_pkg::PROD_W;
    typedef logic [PW-1:0] t_prod;

    lie_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_i, n_i, r_j, n_j, r_n, n_n;
    logic [WW-1:0]   r_xq, n_xq, r_xi, n_xi, r_xj, n_xj, r_basis, n_basis;
    logic signed [WW-1:0] r_acc, n_acc;
    logic            r_sat, n_sat;
    logic [1:0]      r_status, n_status;
    logic [lie_pkg::CFG_W-1:0] r_num_points;
    logic            r_out_valid, n_out_valid;
    logic [WW-1:0]   r_out_value, n_out_value;
    logic [1:0]      r_out_status, n_out_status;

    logic [WW-1:0]   x_mem [MAX_POINTS];
    logic [WW-1:0]   y_mem [MAX_POINTS];
    logic [WW-1:0]   r_x_rd, r_y_rd;
    logic [IW-1:0]   rd_addr;

    lie_pkg::t_alu_req     alu_req;
    lie_pkg::t_alu_rsp     alu_rsp;
    logic signed [DW-1:0]  alu_a, alu_b;
    logic [WW-1:0]         alu_res;

    logic            in_acc;
    logic [CW-1:0]   n_eff;
    logic [CW:0]     j_inc, i_inc, i_inc2;
    logic signed [WW:0] sum;
    lie_pkg::t_clamp sum_c;
    logic            sat_now;

    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        if (r_num_points == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_num_points) > 32'(MAX_POINTS)) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(r_num_points);
        end
    end

    lie_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_rsp   (alu_rsp),
        .o_result(alu_res)
    );

    // point store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.cmd == lie_pkg::CMD_LOAD
                && 32'(i_in.point_index) < 32'(MAX_POINTS)) begin
            x_mem[IW'(i_in.point_index)] <= i_in.x_value;
            y_mem[IW'(i_in.point_index)] <= i_in.y_value;
        end
        r_x_rd <= x_mem[rd_addr];
        r_y_rd <= y_mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_j          = r_j;
        n_n          = r_n;
        n_xq         = r_xq;
        n_xi         = r_xi;
        n_xj         = r_xj;
        n_basis      = r_basis;
        n_acc        = r_acc;
        n_sat        = r_sat;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        rd_addr      = r_i[IW-1:0];
        alu_req      = '{start: 1'b0, op: lie_pkg::OP_MUL};
        alu_a        = '0;
        alu_b        = '0;
        j_inc        = (CW+1)'(r_j) + (CW+1)'(1);
        i_inc        = (CW+1)'(r_i) + (CW+1)'(1);
        i_inc2       = (CW+1)'(r_i) + (CW+1)'(2);
        sat_now      = r_sat | alu_rsp.sat;
        sum          = (WW+1)'(r_acc) + (WW+1)'($signed(alu_res));
        sum_c        = lie_pkg::clamp_mag(sum[WW], sum[WW] ? t_prod'(-sum) : t_prod'(sum));

        case (r_state)
            lie_pkg::ST_IDLE: begin
                if (in_acc && i_in.cmd == lie_pkg::CMD_EVAL) begin
                    n_n   = n_eff;
                    n_xq  = i_in.x_value;
                    n_i   = '0;
                    n_acc = '0;
                    n_sat = 1'b0;
                    n_state = (n_eff == CW'(1)) ? lie_pkg::ST_EV_I : lie_pkg::ST_DUP_I;
                end
            end
            lie_pkg::ST_DUP_I: begin
                rd_addr = r_i[IW-1:0];
                n_j = CW'(i_inc);
                n_state = lie_pkg::ST_DUP_J;
            end
            lie_pkg::ST_DUP_J: begin
                n_xi = r_x_rd;
                rd_addr = r_j[IW-1:0];
                n_state = lie_pkg::ST_DUP_C;
            end
            lie_pkg::ST_DUP_C: begin
                // next address goes out while this pair compares
                rd_addr = j_inc[IW-1:0];
                if (r_x_rd == r_xi) begin
                    n_acc = '0;
                    n_status = lie_pkg::STAT_DUP;
                    n_state = lie_pkg::ST_OUT;
                end else if (j_inc == (CW+1)'(r_n)) begin
                    if (i_inc2 == (CW+1)'(r_n)) begin
                        n_i = '0;
                        n_state = lie_pkg::ST_EV_I;
                    end else begin
                        n_i = CW'(i_inc);
                        n_state = lie_pkg::ST_DUP_I;
                    end
                end else begin
                    n_j = CW'(j_inc);
                end
            end
            lie_pkg::ST_EV_I: begin
                rd_addr = r_i[IW-1:0];
                n_state = lie_pkg::ST_EV_IW;
            end
            lie_pkg::ST_EV_IW: begin
                n_xi = r_x_rd;
                n_basis = WW'(1) << FRAC_BITS;
                n_j = '0;
                n_state = lie_pkg::ST_EV_J;
            end
            lie_pkg::ST_EV_J: begin
                rd_addr = r_j[IW-1:0];
                if (r_j == r_n) begin
                    n_state = lie_pkg::ST_EV_Y;
                end else if (r_j == r_i) begin
                    n_j = CW'(j_inc);
                end else begin
                    n_state = lie_pkg::ST_EV_JW;
                end
            end
            lie_pkg::ST_EV_JW: begin
                n_xj = r_x_rd;
                alu_req = '{start: 1'b1, op: lie_pkg::OP_MUL};
                alu_a = {r_basis[WW-1], r_basis};
                alu_b = $signed({r_xq[WW-1], r_xq}) - $signed({r_x_rd[WW-1], r_x_rd});
                n_state = lie_pkg::ST_EV_MUL;
            end
            lie_pkg::ST_EV_MUL: begin
                if (alu_rsp.done) begin
                    n_sat = sat_now;
                    alu_req = '{start: 1'b1, op: lie_pkg::OP_DIV};
                    alu_a = {alu_res[WW-1], alu_res};
                    alu_b = $signed({r_xi[WW-1], r_xi}) - $signed({r_xj[WW-1], r_xj});
                    n_state = lie_pkg::ST_EV_DIV;
                end
            end
            lie_pkg::ST_EV_DIV: begin
                if (alu_rsp.done) begin
                    n_sat = sat_now;
                    n_basis = alu_res;
                    n_j = CW'(j_inc);
                    n_state = lie_pkg::ST_EV_J;
                end
            end
            lie_pkg::ST_EV_Y: begin
                rd_addr = r_i[IW-1:0];
                n_state = lie_pkg::ST_EV_YW;
            end
            lie_pkg::ST_EV_YW: begin
                alu_req = '{start: 1'b1, op: lie_pkg::OP_MUL};
                alu_a = {r_basis[WW-1], r_basis};
                alu_b = {r_y_rd[WW-1], r_y_rd};
                n_state = lie_pkg::ST_EV_TERM;
            end
            lie_pkg::ST_EV_TERM: begin
                if (alu_rsp.done) begin
                    n_acc = $signed(sum_c.value);
                    n_sat = sat_now | sum_c.sat;
                    n_i = CW'(i_inc);
                    if (i_inc == (CW+1)'(r_n)) begin
                        n_status = (sat_now | sum_c.sat) ? lie_pkg::STAT_SAT
                                                         : lie_pkg::STAT_OK;
                        n_state = lie_pkg::ST_OUT;
                    end else begin
                        n_state = lie_pkg::ST_EV_I;
                    end
                end
            end
            lie_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_acc;
                    n_out_status = r_status;
                    n_state      = lie_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lie_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_num_points <= lie_pkg::CFG_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_num_points <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_n          <= n_n;
        r_xq         <= n_xq;
        r_xi         <= n_xi;
        r_xj         <= n_xj;
        r_basis      <= n_basis;
        r_acc        <= n_acc;
        r_sat        <= n_sat;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_in.ready         = (r_state == lie_pkg::ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.interp_value = r_out_value;
    assign o_out.status       = r_out_status;

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cmd == lie_pkg::CMD_EVAL) |=> !i_in.ready)
        else $error("ready after evaluate beat");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == lie_pkg::ST_OUT))
        else $error("result beat not from output state");

    a_dup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == lie_pkg::STAT_DUP) |-> (o_out.interp_value == '0))
        else $error("duplicate abscissa result not zero");

    a_alu_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |=> !alu_rsp.done)
        else $error("alu done right after start");

endmodule
`default_nettype wire

// ===== verif/lagrange_interpolation_eval_unit_test.sv =====
// testbench for the lagrange interpolation evaluator: random point sets, queries and stalls
`default_nettype none
module lagrange_interpolation_eval_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [lie_pkg::WORD_W-1:0] value;
        logic [1:0]                        status;
    } t_interp;

    class interp_scoreboard;
        logic signed [lie_pkg::WORD_W-1:0] px [16];
        logic signed [lie_pkg::WORD_W-1:0] py [16];
        logic [lie_pkg::CFG_W-1:0]         point_count;
        t_interp                           pending_q[$];
        int                                fails;
        int                                mismatches;

        function new();
            point_count = lie_pkg::CFG_W'(1);
            fails = 0;
            mismatches = 0;
            foreach (px[k]) begin
                px[k] = '0;
                py[k] = '0;
            end
        endfunction

        function logic signed [lie_pkg::WORD_W-1:0] clamp(logic neg, logic [65:0] m,
                                                          inout logic sat);
            if (neg) begin
                if (m > 66'h8000_0000) begin
                    sat = 1'b1;
                    return 32'sh8000_0000;
                end
                return -$signed({1'b0, m[lie_pkg::WORD_W:0]});
            end
            if (m > 66'h7fff_ffff) begin
                sat = 1'b1;
                return 32'sh7fff_ffff;
            end
            return m[lie_pkg::WORD_W-1:0];
        endfunction

        function logic [65:0] mag(longint v);
            return (v < 0) ? 66'(-v) : 66'(v);
        endfunction

        function logic signed [lie_pkg::WORD_W-1:0] fmul(longint a, longint b, inout logic sat);
            logic [65:0] p;
            p = (mag(a) * mag(b)) >> 16;
            return clamp((a < 0) != (b < 0), p, sat);
        endfunction

        function logic signed [lie_pkg::WORD_W-1:0] fdiv(longint a, longint d, inout logic sat);
            logic [65:0] q;
            q = (mag(a) << 16) / mag(d);
            return clamp((a < 0) != (d < 0), q, sat);
        endfunction

        // accepted input beat: update the point store or predict one result
        function void note_item(logic cmd, logic [lie_pkg::IDX_W-1:0] idx,
                                logic signed [lie_pkg::WORD_W-1:0] x,
                                logic signed [lie_pkg::WORD_W-1:0] y);
            int n;
            logic sat;
            longint sum;
            logic signed [lie_pkg::WORD_W-1:0] basis;
            logic signed [lie_pkg::WORD_W-1:0] term;
            t_interp r;
            if (cmd == lie_pkg::CMD_LOAD) begin
                px[idx] = x;
                py[idx] = y;
                return;
            end
            n = int'(point_count);
            if (n < 1) n = 1;
            if (n > 16) n = 16;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (px[i] == px[j]) begin
                        r.value = '0;
                        r.status = lie_pkg::STAT_DUP;
                        pending_q.push_back(r);
                        return;
                    end
            sat = 1'b0;
            sum = 0;
            for (int i = 0; i < n; i++) begin
                basis = 32'sh0001_0000;
                for (int j = 0; j < n; j++) begin
                    if (j == i) continue;
                    basis = fmul(basis, longint'(x) - longint'(px[j]), sat);
                    basis = fdiv(basis, longint'(px[i]) - longint'(px[j]), sat);
                end
                term = fmul(basis, py[i], sat);
                sum += term;
                if (sum > 64'sd2147483647) begin
                    sum = 64'sd2147483647;
                    sat = 1'b1;
                end else if (sum < -64'sd2147483648) begin
                    sum = -64'sd2147483648;
                    sat = 1'b1;
                end
            end
            r.value = sum[lie_pkg::WORD_W-1:0];
            r.status = sat ? lie_pkg::STAT_SAT : lie_pkg::STAT_OK;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [lie_pkg::WORD_W-1:0] v, logic [1:0] s);
            t_interp e;
            if (pending_q.size() == 0) begin
                fails++;
                if (mismatches++ < 10)
                    $display("unexpected result beat: value %h status %0d", v, s);
                return;
            end
            e = pending_q.pop_front();
            if (e.value !== v || e.status !== s) begin
                fails++;
                if (mismatches++ < 10)
                    $display("result mismatch: expected value %h status %0d, got %h status %0d",
                             e.value, e.status, v, s);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    lie_in_if  in_ch();
    lie_out_if out_ch();
    lie_cfg_if cfg_ch();

    interp_scoreboard sb;
    bit calm;
    int hold_left;
    int items_sent;

    lagrange_interpolation_eval_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // result side: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.interp_value, out_ch.status);
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic send_item(logic cmd, logic [lie_pkg::IDX_W-1:0] idx,
                             logic signed [lie_pkg::WORD_W-1:0] x,
                             logic signed [lie_pkg::WORD_W-1:0] y);
        while (!calm && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.point_index <= idx;
        in_ch.x_value <= x;
        in_ch.y_value <= y;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready) break;
        end
        sb.note_item(cmd, idx, x, y);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [lie_pkg::CFG_W-1:0] n);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= n;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        cfg_ch.valid <= 1'b0;
        sb.point_count = n;
    endtask

    // distinct abscissae spread around zero, moderate ordinates or full range
    task automatic load_set(int n, bit wild);
        int step;
        logic signed [lie_pkg::WORD_W-1:0] x;
        logic signed [lie_pkg::WORD_W-1:0] y;
        step = $urandom_range(1, 3) << 16;
        for (int k = 0; k < n; k++) begin
            x = (k - n / 2) * step + $urandom_range(0, 16'h7fff);
            y = wild ? $signed($urandom) : $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            send_item(lie_pkg::CMD_LOAD, k[lie_pkg::IDX_W-1:0], x, y);
        end
    endtask

    initial begin
        int n;
        logic signed [lie_pkg::WORD_W-1:0] q;
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        calm = 1'b0;
        hold_left = 0;
        items_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.cmd = lie_pkg::CMD_LOAD;
        in_ch.point_index = '0;
        in_ch.x_value = '0;
        in_ch.y_value = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill every slot, field extremes, duplicates, count extremes
        for (int k = 0; k < 16; k++)
            send_item(lie_pkg::CMD_LOAD, k[lie_pkg::IDX_W-1:0], (k - 8) <<< 16,
                      (k == 0) ? 32'sh7fff_ffff : (k == 1) ? 32'sh8000_0000 : (k * 3) <<< 15);
        send_item(lie_pkg::CMD_EVAL, 4'hf, 32'sh0, 32'sh7fff_ffff);
        write_count(lie_pkg::CFG_W'(3));
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh7fff_ffff, 32'sh0);
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh8000_0000, 32'sh0);
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh0001_8000, 32'sh0);
        send_item(lie_pkg::CMD_LOAD, 4'h2, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh0000_4000, 32'sh0);
        send_item(lie_pkg::CMD_LOAD, 4'h1, 32'sh7fff_ffff, 32'sh0001_0000);
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh0, 32'sh0);
        write_count(lie_pkg::CFG_W'(0));
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh0002_0000, 32'sh0);
        send_item(lie_pkg::CMD_LOAD, 4'h1, 32'sh8000_0000, 32'sh0002_0000);
        send_item(lie_pkg::CMD_LOAD, 4'h2, 32'sh0000_0100, 32'sh0002_0000);
        write_count(lie_pkg::CFG_W'(31));
        send_item(lie_pkg::CMD_EVAL, 4'h0, 32'sh0000_8000, 32'sh0);

        // random: point sets with queries, occasional noise and duplicates
        for (int round = 0; items_sent < 100; round++) begin
            calm = (round >= 3 && round < 7);
            if (round % 9 == 8) n = 16;
            else if (round % 11 == 5) n = $urandom_range(0, 1);
            else n = $urandom_range(2, 6);
            write_count(lie_pkg::CFG_W'(n));
            load_set((n < 1) ? 1 : (n > 16 ? 16 : n), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                send_item(lie_pkg::CMD_LOAD, lie_pkg::IDX_W'($urandom_range(0, 15)),
                          $signed($urandom), $signed($urandom));
            if (n > 1 && $urandom_range(0, 6) == 0)
                send_item(lie_pkg::CMD_LOAD, 4'h1, sb.px[0], $signed($urandom));
            if (round == 2) hold_left = 3000;
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) == 0)
                    q = $signed($urandom);
                else
                    q = $signed($urandom_range(0, 12 << 16)) - (6 << 16);
                send_item(lie_pkg::CMD_EVAL, lie_pkg::IDX_W'($urandom_range(0, 15)), q,
                          $signed($urandom));
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_q.size() == 0)
            $display("lagrange_interpolation_eval_unit verification clean");
        else
            $display("lagrange_interpolation_eval_unit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("lagrange_interpolation_eval_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
